FILE: hdl/mfa_pkg.sv
// mfa_pkg: widths, codes and command/status types for mixed_fraction_arithmetic
// no dependencies; imported by every module of the block

package mfa_pkg;

  // operand field width and derived datapath widths
  localparam int unsigned FIELD_W = 12;
  localparam int unsigned N_W     = 2 * FIELD_W + 1;   // improper numerator
  localparam int unsigned NUM_W   = 2 * N_W;           // products and result numerator
  localparam int unsigned DEN_W   = 3 * FIELD_W + 1;   // result denominator
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned K_W     = $clog2(DEN_W + 1);
  localparam int unsigned CNT_W   = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_DIV_ZERO = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    MUL_N1,
    MUL_N2,
    MUL_T1,
    MUL_T2,
    MUL_T3
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_WHOLE,
    DIV_NUMER,
    DIV_DENOM
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_N1,
    ST_N2,
    ST_CHK,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_COMB,
    ST_QW_GO,
    ST_QW_WAIT,
    ST_REMCHK,
    ST_GCD_INIT,
    ST_GCD,
    ST_GMAKE,
    ST_QN_GO,
    ST_QN_WAIT,
    ST_QD_GO,
    ST_QD_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     combine;
    logic     div_start;
    logic     div_cap;
    div_sel_e div_sel;
    logic     gcd_init;
    logic     gcd_step;
    logic     gmake;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic err_zero_den;
    logic err_div_zero;
    logic rem_zero;
    logic gcd_done;
    logic div_busy;
  } sts_t;

endpackage

FILE: hdl/mfa_divider.sv
// mfa_divider: restoring divider, one quotient bit per cycle
// depends on mfa_pkg

module mfa_divider
  import mfa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0] dvs_q, dvs_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  // shift in next dividend bit and trial subtract
  always_comb begin
    shifted = {acc_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    acc_d   = acc_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = dividend_i;
      acc_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DEN_W]) begin
        acc_d = diff[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        acc_d = shifted[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    acc_q <= acc_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = acc_q;

endmodule

FILE: hdl/mfa_datapath.sv
// mfa_datapath: operand registers, shared multiplier, sign combine, binary gcd,
// divider and result registers; depends on mfa_pkg and mfa_divider

module mfa_datapath
  import mfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [1:0]         mode_i,
  input  logic               first_sign_i,
  input  logic [FIELD_W-1:0] first_whole_i,
  input  logic [FIELD_W-1:0] first_numer_i,
  input  logic [FIELD_W-1:0] first_denom_i,
  input  logic               second_sign_i,
  input  logic [FIELD_W-1:0] second_whole_i,
  input  logic [FIELD_W-1:0] second_numer_i,
  input  logic [FIELD_W-1:0] second_denom_i,
  output logic               result_sign_o,
  output logic [OUT_W-1:0]   result_whole_o,
  output logic [OUT_W-1:0]   result_numer_o,
  output logic [OUT_W-1:0]   result_denom_o,
  output logic [1:0]         error_code_o
);

  mode_e              mode_q;
  logic               s1_q, s2_q;
  logic [FIELD_W-1:0] w1_q, f1_q, d1_q, w2_q, f2_q, d2_q;
  logic [N_W-1:0]     n1_q, n2_q;
  logic [NUM_W-1:0]   t1_q, t2_q, num_q, whole_q;
  logic [DEN_W-1:0]   den_q, rem_q, ga_q, gb_q, g_q, numer_q, dred_q;
  logic [K_W-1:0]     k_q;
  logic               neg_q;

  logic               res_sign_q;
  logic [OUT_W-1:0]   res_whole_q, res_numer_q, res_denom_q;
  logic [1:0]         res_err_q;

  // input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      s1_q   <= first_sign_i;
      w1_q   <= first_whole_i;
      f1_q   <= first_numer_i;
      d1_q   <= first_denom_i;
      s2_q   <= second_sign_i;
      w2_q   <= second_whole_i;
      f2_q   <= second_numer_i;
      d2_q   <= second_denom_i;
    end
  end

  // shared multiply-add
  logic [N_W-1:0]     ma, mb;
  logic [FIELD_W-1:0] mc;
  logic [NUM_W-1:0]   prod;

  always_comb begin
    ma = N_W'(w1_q);
    mb = N_W'(d1_q);
    mc = '0;
    case (cmd_i.mul_sel)
      MUL_N1: begin
        ma = N_W'(w1_q);
        mb = N_W'(d1_q);
        mc = f1_q;
      end
      MUL_N2: begin
        ma = N_W'(w2_q);
        mb = N_W'(d2_q);
        mc = f2_q;
      end
      MUL_T1: begin
        ma = n1_q;
        mb = (mode_q == MODE_MUL) ? n2_q : N_W'(d2_q);
      end
      MUL_T2: begin
        ma = n2_q;
        mb = N_W'(d1_q);
      end
      MUL_T3: begin
        ma = N_W'(d1_q);
        mb = (mode_q == MODE_DIV) ? n2_q : N_W'(d2_q);
      end
      default: ;
    endcase
    prod = NUM_W'(ma) * NUM_W'(mb) + NUM_W'(mc);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_N1:  n1_q  <= prod[N_W-1:0];
        MUL_N2:  n2_q  <= prod[N_W-1:0];
        MUL_T1:  t1_q  <= prod;
        MUL_T2:  t2_q  <= prod;
        MUL_T3:  den_q <= prod[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  // signed combine of cross products
  logic             sa, sb, ng;
  logic [NUM_W-1:0] mag;

  always_comb begin
    sa = s1_q;
    sb = (mode_q == MODE_SUB) ? ~s2_q : s2_q;
    if (mode_q == MODE_ADD || mode_q == MODE_SUB) begin
      if (sa == sb) begin
        mag = t1_q + t2_q;
        ng  = sa;
      end else if (t1_q >= t2_q) begin
        mag = t1_q - t2_q;
        ng  = sa;
      end else begin
        mag = t2_q - t1_q;
        ng  = sb;
      end
    end else begin
      mag = t1_q;
      ng  = s1_q ^ s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.combine) begin
      num_q <= mag;
      neg_q <= ng & (mag != '0);
    end
  end

  // shared divider
  logic [NUM_W-1:0] dividend, quot;
  logic [DEN_W-1:0] divisor, drem;
  logic             div_busy;

  always_comb begin
    dividend = num_q;
    divisor  = den_q;
    case (cmd_i.div_sel)
      DIV_WHOLE: begin
        dividend = num_q;
        divisor  = den_q;
      end
      DIV_NUMER: begin
        dividend = NUM_W'(rem_q);
        divisor  = g_q;
      end
      DIV_DENOM: begin
        dividend = NUM_W'(den_q);
        divisor  = g_q;
      end
      default: ;
    endcase
  end

  mfa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (drem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_cap) begin
      case (cmd_i.div_sel)
        DIV_WHOLE: begin
          whole_q <= quot;
          rem_q   <= drem;
        end
        DIV_NUMER: numer_q <= quot[DEN_W-1:0];
        DIV_DENOM: dred_q  <= quot[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  // binary gcd, one step per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      ga_q <= rem_q;
      gb_q <= den_q;
      k_q  <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        k_q  <= k_q + K_W'(1);
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q > gb_q) begin
        ga_q <= (ga_q - gb_q) >> 1;
      end else begin
        gb_q <= (gb_q - ga_q) >> 1;
      end
    end
    if (cmd_i.gmake) g_q <= ga_q << k_q;
  end

  // result formatting with whole part saturation
  logic [OUT_W+NUM_W-1:0] whole_x;
  logic [OUT_W+DEN_W-1:0] numer_x, denom_x;
  logic [OUT_W-1:0]       whole_sat;
  logic                   rem_zero;

  always_comb begin
    whole_x   = {{OUT_W{1'b0}}, whole_q};
    numer_x   = {{OUT_W{1'b0}}, numer_q};
    denom_x   = {{OUT_W{1'b0}}, dred_q};
    whole_sat = (|whole_x[OUT_W+NUM_W-1:OUT_W]) ? '1 : whole_x[OUT_W-1:0];
    rem_zero  = (rem_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (sts_o.err_zero_den || sts_o.err_div_zero) begin
        res_sign_q  <= 1'b0;
        res_whole_q <= '0;
        res_numer_q <= '0;
        res_denom_q <= '0;
        res_err_q   <= sts_o.err_zero_den ? ERR_ZERO_DEN : ERR_DIV_ZERO;
      end else begin
        res_sign_q  <= neg_q;
        res_whole_q <= whole_sat;
        res_numer_q <= rem_zero ? '0 : numer_x[OUT_W-1:0];
        res_denom_q <= rem_zero ? OUT_W'(1) : denom_x[OUT_W-1:0];
        res_err_q   <= ERR_NONE;
      end
    end
  end

  // status to controller
  always_comb begin
    sts_o.err_zero_den = (d1_q == '0) || (d2_q == '0);
    sts_o.err_div_zero = (mode_q == MODE_DIV) && (n2_q == '0);
    sts_o.rem_zero     = rem_zero;
    sts_o.gcd_done     = (ga_q == gb_q);
    sts_o.div_busy     = div_busy;
  end

  assign result_sign_o  = res_sign_q;
  assign result_whole_o = res_whole_q;
  assign result_numer_o = res_numer_q;
  assign result_denom_o = res_denom_q;
  assign error_code_o   = res_err_q;

endmodule

FILE: hdl/mfa_ctrl.sv
// mfa_ctrl: sequencer for one word at a time and output valid register
// depends on mfa_pkg

module mfa_ctrl
  import mfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_N1;
    cmd_o.div_sel = DIV_WHOLE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_N1;
        end
      end
      ST_N1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_N1;
        state_d       = ST_N2;
      end
      ST_N2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_N2;
        state_d       = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.err_zero_den || sts_i.err_div_zero) state_d = ST_OUT;
        else state_d = ST_T1;
      end
      ST_T1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_T1;
        state_d       = ST_T2;
      end
      ST_T2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_T2;
        state_d       = ST_T3;
      end
      ST_T3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_T3;
        state_d       = ST_COMB;
      end
      ST_COMB: begin
        cmd_o.combine = 1'b1;
        state_d       = ST_QW_GO;
      end
      ST_QW_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_WHOLE;
        state_d         = ST_QW_WAIT;
      end
      ST_QW_WAIT: begin
        cmd_o.div_sel = DIV_WHOLE;
        if (!sts_i.div_busy) begin
          cmd_o.div_cap = 1'b1;
          state_d       = ST_REMCHK;
        end
      end
      ST_REMCHK: begin
        if (sts_i.rem_zero) state_d = ST_OUT;
        else state_d = ST_GCD_INIT;
      end
      ST_GCD_INIT: begin
        cmd_o.gcd_init = 1'b1;
        state_d        = ST_GCD;
      end
      ST_GCD: begin
        if (sts_i.gcd_done) state_d = ST_GMAKE;
        else cmd_o.gcd_step = 1'b1;
      end
      ST_GMAKE: begin
        cmd_o.gmake = 1'b1;
        state_d     = ST_QN_GO;
      end
      ST_QN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_NUMER;
        state_d         = ST_QN_WAIT;
      end
      ST_QN_WAIT: begin
        cmd_o.div_sel = DIV_NUMER;
        if (!sts_i.div_busy) begin
          cmd_o.div_cap = 1'b1;
          state_d       = ST_QD_GO;
        end
      end
      ST_QD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DENOM;
        state_d         = ST_QD_WAIT;
      end
      ST_QD_WAIT: begin
        cmd_o.div_sel = DIV_DENOM;
        if (!sts_i.div_busy) begin
          cmd_o.div_cap = 1'b1;
          state_d       = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // accepted word starts the sequence
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_N1))
    else $error("accepted word did not start the sequence");

  // result register never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // divider started only when free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  // loading a result always raises valid
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result loaded without valid");

endmodule

FILE: hdl/mixed_fraction_arithmetic.sv
// mixed_fraction_arithmetic: top level, joins controller and datapath
// depends on mfa_pkg, mfa_ctrl, mfa_datapath
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o  mode, two signed mixed operands
//   out      output     out_valid_o/out_stall_i sign, whole, numer, denom, error
//
// one word at a time; a word with an error skips the cross products and the divider,
// one with a zero remainder skips the gcd loop and the two reducing divides, and
// the rest take three passes of the shared bit-serial divider and the gcd loop
// rst_ni clears the sequencer and output valid; no clearing pass
// a waiting result does not block intake; a new result waits in ST_OUT for space

module mixed_fraction_arithmetic
  import mfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic               first_sign_i,
  input  logic [FIELD_W-1:0] first_whole_i,
  input  logic [FIELD_W-1:0] first_numer_i,
  input  logic [FIELD_W-1:0] first_denom_i,
  input  logic               second_sign_i,
  input  logic [FIELD_W-1:0] second_whole_i,
  input  logic [FIELD_W-1:0] second_numer_i,
  input  logic [FIELD_W-1:0] second_denom_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_sign_o,
  output logic [OUT_W-1:0]   result_whole_o,
  output logic [OUT_W-1:0]   result_numer_o,
  output logic [OUT_W-1:0]   result_denom_o,
  output logic [1:0]         error_code_o
);

  cmd_t cmd;
  sts_t sts;

  mfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mfa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .first_sign_i   (first_sign_i),
    .first_whole_i  (first_whole_i),
    .first_numer_i  (first_numer_i),
    .first_denom_i  (first_denom_i),
    .second_sign_i  (second_sign_i),
    .second_whole_i (second_whole_i),
    .second_numer_i (second_numer_i),
    .second_denom_i (second_denom_i),
    .result_sign_o  (result_sign_o),
    .result_whole_o (result_whole_o),
    .result_numer_o (result_numer_o),
    .result_denom_o (result_denom_o),
    .error_code_o   (error_code_o)
  );

endmodule

FILE: sim/mixed_fraction_arithmetic_test.sv
// mixed_fraction_arithmetic_test: self-checking bench for mixed fraction arithmetic
// depends on mfa_pkg and mixed_fraction_arithmetic; computes expected words locally

`timescale 1ns / 100ps

module mixed_fraction_arithmetic_test;
  import mfa_pkg::*;

  typedef struct packed {
    mode_e              mode;
    logic               s1;
    logic [FIELD_W-1:0] w1, f1, d1;
    logic               s2;
    logic [FIELD_W-1:0] w2, f2, d2;
  } operands_t;

  typedef struct packed {
    logic             sign;
    logic [OUT_W-1:0] whole, numer, denom;
    err_e             err;
  } fraction_t;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 3000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] mode_i;
  logic first_sign_i, second_sign_i;
  logic [FIELD_W-1:0] first_whole_i, first_numer_i, first_denom_i;
  logic [FIELD_W-1:0] second_whole_i, second_numer_i, second_denom_i;
  logic out_valid_o, out_stall_i;
  logic result_sign_o;
  logic [OUT_W-1:0] result_whole_o, result_numer_o, result_denom_o;
  logic [1:0] error_code_o;

  operands_t pending_q[$];
  fraction_t expected_q[$];
  int unsigned fail_count, idle_cycles, words_in, words_out, err_words;
  int unsigned send_gap, recv_gap, hold_left;
  bit quiet_tail, hold_started;
  bit in_taken;
  operands_t cur;

  mixed_fraction_arithmetic dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned gcd_u(longint unsigned p, longint unsigned q);
    longint unsigned t;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p;
  endfunction

  // expected word for one operand set
  function automatic fraction_t evaluate(operands_t x);
    fraction_t r;
    longint unsigned n1, n2, num, den, whole, rem, g;
    longint sa, sb, total;
    bit neg;
    r = '0;
    r.err = ERR_NONE;
    if (x.d1 == 0 || x.d2 == 0) begin
      r.err = ERR_ZERO_DEN;
      return r;
    end
    n1 = x.w1 * x.d1 + x.f1;
    n2 = x.w2 * x.d2 + x.f2;
    if (x.mode == MODE_DIV && n2 == 0) begin
      r.err = ERR_DIV_ZERO;
      return r;
    end
    case (x.mode)
      MODE_ADD, MODE_SUB: begin
        sa = n1 * x.d2;
        sb = n2 * x.d1;
        if (x.s1) sa = -sa;
        if ((x.mode == MODE_SUB) ? !x.s2 : x.s2) sb = -sb;
        total = sa + sb;
        neg = total < 0;
        num = neg ? -total : total;
        den = x.d1 * x.d2;
      end
      MODE_MUL: begin
        num = n1 * n2;
        den = x.d1 * x.d2;
        neg = x.s1 ^ x.s2;
      end
      default: begin
        num = n1 * x.d2;
        den = x.d1 * n2;
        neg = x.s1 ^ x.s2;
      end
    endcase
    if (num == 0) neg = 0;
    whole = num / den;
    rem = num % den;
    if (rem == 0) begin
      den = 1;
    end else begin
      g = gcd_u(rem, den);
      rem = rem / g;
      den = den / g;
    end
    if (whole > 64'hFFFF_FFFF_FFFF) whole = 64'hFFFF_FFFF_FFFF;
    r.sign = neg;
    r.whole = whole[OUT_W-1:0];
    r.numer = rem[OUT_W-1:0];
    r.denom = den[OUT_W-1:0];
    return r;
  endfunction

  function automatic operands_t make_ops(mode_e m, bit a, int wa, int fa, int da,
                                         bit b, int wb, int fb, int db);
    operands_t x;
    x.mode = m;
    x.s1 = a; x.w1 = FIELD_W'(wa); x.f1 = FIELD_W'(fa); x.d1 = FIELD_W'(da);
    x.s2 = b; x.w2 = FIELD_W'(wb); x.f2 = FIELD_W'(fb); x.d2 = FIELD_W'(db);
    return x;
  endfunction

  // random field leaning on small, edge and full-range values
  function automatic logic [FIELD_W-1:0] pick_field(bit nonzero);
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '1;
      1: v = FIELD_W'($urandom_range(0, 3));
      2, 3: v = FIELD_W'($urandom_range(0, 40));
      default: v = FIELD_W'($urandom);
    endcase
    if (nonzero && v == '0) v = FIELD_W'(1);
    return v;
  endfunction

  // driver: offers words from the pending queue with random gaps
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid_i || in_taken) begin
      if (in_valid_i) void'(pending_q.pop_front());
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 16);
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur = pending_q[0];
        in_valid_i <= 1'b1;
        mode_i <= cur.mode;
        first_sign_i <= cur.s1;
        first_whole_i <= cur.w1;
        first_numer_i <= cur.f1;
        first_denom_i <= cur.d1;
        second_sign_i <= cur.s2;
        second_whole_i <= cur.w2;
        second_numer_i <= cur.f2;
        second_denom_i <= cur.d2;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall: random bursts, one long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      hold_started <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_started && words_in == 400) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: predict on intake, compare on delivery
  always @(posedge clk_i) begin
    fraction_t exp_w;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(evaluate(make_ops(mode_e'(mode_i), first_sign_i,
          first_whole_i, first_numer_i, first_denom_i, second_sign_i,
          second_whole_i, second_numer_i, second_denom_i)));
        words_in <= words_in + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        words_out <= words_out + 1;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_q.pop_front();
          if (exp_w.err != ERR_NONE) err_words <= err_words + 1;
          if (result_sign_o !== exp_w.sign ||
              result_whole_o !== exp_w.whole ||
              result_numer_o !== exp_w.numer ||
              result_denom_o !== exp_w.denom ||
              error_code_o !== exp_w.err) begin
            if (result_sign_o !== exp_w.sign)
              $error("result_sign expected %0d actual %0d", exp_w.sign, result_sign_o);
            if (result_whole_o !== exp_w.whole)
              $error("result_whole expected %0d actual %0d", exp_w.whole, result_whole_o);
            if (result_numer_o !== exp_w.numer)
              $error("result_numer expected %0d actual %0d", exp_w.numer, result_numer_o);
            if (result_denom_o !== exp_w.denom)
              $error("result_denom expected %0d actual %0d", exp_w.denom, result_denom_o);
            if (error_code_o !== exp_w.err)
              $error("error_code expected %0d actual %0d", exp_w.err, error_code_o);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d words outstanding", expected_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    operands_t x;
    in_valid_i = 1'b0; out_stall_i = 1'b0; mode_i = '0;
    first_sign_i = 0; first_whole_i = '0; first_numer_i = '0; first_denom_i = '0;
    second_sign_i = 0; second_whole_i = '0; second_numer_i = '0; second_denom_i = '0;
    fail_count = 0; idle_cycles = 0; words_in = 0; words_out = 0; err_words = 0;
    quiet_tail = 0;
    rst_ni = 1'b0;

    // directed words: each operation, zero denominators, divide by zero, zero
    // result, extremes, signs
    pending_q.push_back(make_ops(MODE_ADD, 0, 1, 1, 2, 0, 2, 1, 3));
    pending_q.push_back(make_ops(MODE_SUB, 0, 1, 1, 2, 1, 2, 1, 3));
    pending_q.push_back(make_ops(MODE_MUL, 1, 3, 2, 5, 0, 1, 3, 4));
    pending_q.push_back(make_ops(MODE_DIV, 1, 3, 2, 5, 1, 1, 3, 4));
    pending_q.push_back(make_ops(MODE_ADD, 0, 5, 1, 0, 0, 1, 1, 2));
    pending_q.push_back(make_ops(MODE_MUL, 0, 5, 1, 3, 1, 1, 1, 0));
    pending_q.push_back(make_ops(MODE_DIV, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_ops(MODE_DIV, 0, 7, 3, 4, 1, 0, 0, 9));
    pending_q.push_back(make_ops(MODE_SUB, 1, 2, 1, 3, 1, 2, 1, 3));
    pending_q.push_back(make_ops(MODE_SUB, 0, 2, 1, 3, 0, 2, 1, 3));
    pending_q.push_back(make_ops(MODE_ADD, 1, 2, 1, 3, 0, 2, 1, 3));
    pending_q.push_back(make_ops(MODE_MUL, 1, 0, 0, 7, 0, 4, 1, 2));
    pending_q.push_back(make_ops(MODE_DIV, 1, 0, 0, 7, 1, 4, 1, 2));
    for (int m = 0; m < 4; m++) begin
      pending_q.push_back(make_ops(mode_e'(m), 1, 4095, 4095, 4095, 0, 4095, 4095, 4095));
      pending_q.push_back(make_ops(mode_e'(m), 0, 4095, 4095, 1, 1, 0, 1, 4095));
    end
    pending_q.push_back(make_ops(MODE_ADD, 0, 0, 4095, 1, 0, 0, 4095, 1));
    pending_q.push_back(make_ops(MODE_DIV, 0, 0, 1, 4095, 0, 4095, 4095, 1));
    pending_q.push_back(make_ops(MODE_MUL, 1, 0, 5, 3, 1, 0, 7, 2));

    // random words, rare errors
    for (int i = 0; i < 1580; i++) begin
      x.mode = mode_e'($urandom_range(0, 3));
      x.s1 = 1'($urandom); x.s2 = 1'($urandom);
      x.w1 = pick_field(0); x.f1 = pick_field(0);
      x.w2 = pick_field(0); x.f2 = pick_field(0);
      x.d1 = pick_field($urandom_range(0, 30) != 0);
      x.d2 = pick_field($urandom_range(0, 30) != 0);
      pending_q.push_back(x);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // last stretch without idling
    wait (pending_q.size() < 150);
    quiet_tail = 1;
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (300) @(posedge clk_i);

    $display("%0d words sent, %0d results checked, %0d error words; all four ops,",
             words_in, words_out, err_words);
    $display("zero denominators, divide by zero, sign and range extremes, long output stall");
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: mixed_fraction_arithmetic.f
hdl/mfa_pkg.sv
hdl/mfa_divider.sv
hdl/mfa_datapath.sv
hdl/mfa_ctrl.sv
hdl/mixed_fraction_arithmetic.sv
sim/mixed_fraction_arithmetic_test.sv
